>>> rtl/gfpd_pkg.sv
package gfpd_pkg;

    localparam int MAG_W  = 16;  // magnitude of the signed reading
    localparam int P1_W   = 20;  // factor a numerator times mantissa tenths
    localparam int P2_W   = 33;  // p1 times exponent numerator
    localparam int NUM_W  = 48;  // reading magnitude times p2
    localparam int D1_W   = 29;  // factor a denominator times factor b
    localparam int DEN_W  = 42;  // d1 times ten times exponent denominator
    localparam int FSH_W  = 33;  // fraction bits produced plus one rounding bit
    localparam int QUO_W  = 66;  // quotient bits kept by the divider
    localparam int INT_W  = QUO_W - FSH_W;
    localparam int CNT_W  = 7;   // divider step counter
    localparam int RES_W  = 64;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);
    localparam logic [INT_W-1:0] INT_LIMIT = INT_W'(33'h0_8000_0000);
    localparam logic [RES_W-1:0] RES_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [RES_W-1:0] RES_MIN = 64'h8000_0000_0000_0000;

    localparam logic [7:0] PAGE_SCALE_A = 8'd2;
    localparam logic [7:0] PAGE_SCALE_B = 8'd3;
    localparam logic [7:0] PAGE_DIVISOR = 8'd4;

    localparam logic [1:0] UNIT_MILLIBAR = 2'd0;
    localparam logic [1:0] UNIT_MMHG     = 2'd1;
    localparam logic [1:0] UNIT_PA       = 2'd2;

    localparam logic [2:0] FA_MBAR     = 3'd1;
    localparam logic [2:0] FA_TORR     = 3'd2;
    localparam logic [2:0] FA_PA       = 3'd3;
    localparam logic [2:0] FA_MBAR_ALT = 3'd4;
    localparam logic [2:0] FB_24000    = 3'd1;
    localparam logic [2:0] FB_32000    = 3'd2;
    localparam logic [2:0] FB_26400    = 3'd3;
    localparam logic [2:0] FB_32767    = 3'd4;

    localparam logic [3:0] MCODE_MAX   = 4'd4;
    localparam logic [3:0] MCODE_ALT   = 4'd1;
    localparam logic [3:0] XCODE_MAX   = 4'd7;

    typedef struct packed {
        logic             ok;
        logic             ready;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [1:0]       unit;
        logic [7:0]       err;
        logic [2:0]       a_code;
        logic [2:0]       b_code;
        logic [2:0]       m_code;
        logic [3:0]       e_code;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_LOAD,
        ST_DIV,
        ST_ROUND,
        ST_DONE
    } back_state_t;

    function automatic logic codes_ready(input logic [2:0] a, input logic [2:0] b,
                                         input logic [2:0] m, input logic [3:0] e);
        codes_ready = (a >= 3'd1) && (a <= 3'd4) && (b >= 3'd1) && (b <= 3'd4) &&
                      (m >= 3'd1) && (m <= 3'd5) && (e >= 4'd1) && (e <= 4'd8);
    endfunction

    function automatic logic [13:0] a_num_of(input logic [2:0] code);
        unique case (code)
            FA_MBAR:     a_num_of = 14'd13332;
            FA_TORR:     a_num_of = 14'd1;
            FA_PA:       a_num_of = 14'd13332;
            FA_MBAR_ALT: a_num_of = 14'd13332;
            default:     a_num_of = 14'd0;
        endcase
    endfunction

    function automatic logic [13:0] a_den_of(input logic [2:0] code);
        unique case (code)
            FA_MBAR: a_den_of = 14'd10000;
            FA_PA:   a_den_of = 14'd100;
            default: a_den_of = 14'd1;
        endcase
    endfunction

    function automatic logic [14:0] b_val_of(input logic [2:0] code);
        unique case (code)
            FB_24000: b_val_of = 15'd24000;
            FB_32000: b_val_of = 15'd32000;
            FB_26400: b_val_of = 15'd26400;
            FB_32767: b_val_of = 15'd32767;
            default:  b_val_of = 15'd1;
        endcase
    endfunction

    // mantissa in tenths
    function automatic logic [5:0] m_tenths_of(input logic [2:0] code);
        unique case (code)
            3'd1:    m_tenths_of = 6'd10;
            3'd2:    m_tenths_of = 6'd11;
            3'd3:    m_tenths_of = 6'd20;
            3'd4:    m_tenths_of = 6'd25;
            3'd5:    m_tenths_of = 6'd50;
            default: m_tenths_of = 6'd0;
        endcase
    endfunction

    // positive powers of ten, code 4 stands for 10^0
    function automatic logic [13:0] e_num_of(input logic [3:0] code);
        unique case (code)
            4'd5:    e_num_of = 14'd10;
            4'd6:    e_num_of = 14'd100;
            4'd7:    e_num_of = 14'd1000;
            4'd8:    e_num_of = 14'd10000;
            default: e_num_of = 14'd1;
        endcase
    endfunction

    // ten times the negative power of ten
    function automatic logic [13:0] e_den10_of(input logic [3:0] code);
        unique case (code)
            4'd1:    e_den10_of = 14'd10000;
            4'd2:    e_den10_of = 14'd1000;
            4'd3:    e_den10_of = 14'd100;
            default: e_den10_of = 14'd10;
        endcase
    endfunction

endpackage

>>> rtl/gauge_frame_pressure_decoder.sv
// gauge frame pressure decoder
//
// input channel: one nine-byte gauge frame per request, one port per byte;
//   a request is taken on a rising edge with push high and full low
// result channel: one result per frame, in frame order; the oldest result
//   sits on frame_ok, pressure, unit_code, error_flags and scale_ready while
//   empty is low, and is taken on a rising edge with pop high
// the front checks the checksum and updates the scaling codes in the cycle
//   the frame is taken, then queues a command for the back
// the back spends a take step, three multiply steps, a load step, a
//   restoring divider that yields one quotient bit per step until the
//   quotient is full, a round step and a write step; it takes no new
//   command from the queue until the last one is written
// a frame that fails the checksum or arrives before all codes are set skips
//   the arithmetic; the back goes from the take step straight to the write step
// while a result waits unread, the back finishes the next command and holds
//   at the write step; frames keep entering until the queue fills
// reset clears the scaling codes, the queue and the result
//   valid flag; nothing is left in flight
module gauge_frame_pressure_decoder #(
    parameter int QUEUE_DEPTH = 2  // command queue entries, two or more
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         frame_length,  // rides along, plays no part in decoding
    input  logic [7:0]         page_number,
    input  logic [7:0]         status_byte,
    input  logic [7:0]         error_byte,
    input  logic [7:0]         value_high,
    input  logic [7:0]         value_low,
    input  logic [7:0]         query_byte,
    input  logic [7:0]         type_byte,
    input  logic [7:0]         check_byte,
    output logic               empty,
    input  logic               pop,
    output logic               frame_ok,
    output logic signed [63:0] pressure,
    output logic [1:0]         unit_code,
    output logic [7:0]         error_flags,
    output logic               scale_ready
);
    import gfpd_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic accept;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic res_valid;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !res_valid;

    // checksum, scaling code update, command build
    gfpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .page_number  (page_number),
        .status_byte  (status_byte),
        .error_byte   (error_byte),
        .value_high   (value_high),
        .value_low    (value_low),
        .query_byte   (query_byte),
        .type_byte    (type_byte),
        .check_byte   (check_byte),
        .cmd          (front_cmd)
    );

    // short command queue between front and back
    gfpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (back_cmd),
        .empty   (q_empty)
    );

    // multiply, divide, round, saturate and hold the result
    gfpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (back_cmd),
        .cmd_empty    (q_empty),
        .cmd_pop      (q_pop),
        .res_valid    (res_valid),
        .res_pop      (pop),
        .res_ok       (frame_ok),
        .res_pressure (pressure),
        .res_unit     (unit_code),
        .res_err      (error_flags),
        .res_ready    (scale_ready)
    );

endmodule

>>> rtl/gfpd_front.sv
module gfpd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    page_number,
    input  logic [7:0]    status_byte,
    input  logic [7:0]    error_byte,
    input  logic [7:0]    value_high,
    input  logic [7:0]    value_low,
    input  logic [7:0]    query_byte,
    input  logic [7:0]    type_byte,
    input  logic [7:0]    check_byte,
    output gfpd_pkg::cmd_t cmd
);
    import gfpd_pkg::*;

    logic [2:0]  a_code_reg, a_code_next;
    logic [2:0]  b_code_reg, b_code_next;
    logic [2:0]  m_code_reg, m_code_next;
    logic [3:0]  e_code_reg, e_code_next;
    logic [7:0]  sum;
    logic        sum_ok;
    logic [1:0]  unit;
    logic [3:0]  mcode;
    logic [3:0]  xcode;
    logic [15:0] raw;

    assign sum = page_number + status_byte + error_byte + value_high + value_low +
                 query_byte + type_byte;
    assign sum_ok = (sum == check_byte);
    assign unit   = status_byte[5:4];
    assign mcode  = type_byte[7:4];
    assign xcode  = type_byte[3:0];
    assign raw    = {value_high, value_low};

    always_comb
    begin
        a_code_next = a_code_reg;
        b_code_next = b_code_reg;
        m_code_next = m_code_reg;
        e_code_next = e_code_reg;
        if (sum_ok)
        begin
            if (page_number == PAGE_SCALE_A || page_number == PAGE_SCALE_B)
            begin
                if (xcode <= XCODE_MAX)
                    e_code_next = xcode + 4'd1;
                if (mcode <= MCODE_MAX)
                    m_code_next = mcode[2:0] + 3'd1;
                if (mcode != MCODE_ALT)
                begin
                    priority if (unit == UNIT_MILLIBAR)
                    begin
                        a_code_next = FA_MBAR;
                        b_code_next = FB_24000;
                    end
                    else if (unit == UNIT_MMHG)
                    begin
                        a_code_next = FA_TORR;
                        b_code_next = FB_32000;
                    end
                    else if (unit == UNIT_PA)
                    begin
                        a_code_next = FA_PA;
                        b_code_next = FB_24000;
                    end
                    else
                    begin
                        // unit 3 keeps the stored pair
                        a_code_next = a_code_reg;
                        b_code_next = b_code_reg;
                    end
                end
                else if (unit == UNIT_MILLIBAR)
                begin
                    a_code_next = FA_MBAR_ALT;
                    b_code_next = FB_26400;
                end
            end
            else if (page_number == PAGE_DIVISOR)
            begin
                b_code_next = FB_32767;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_code_reg <= '0;
            b_code_reg <= '0;
            m_code_reg <= '0;
            e_code_reg <= '0;
        end
        else if (accept)
        begin
            a_code_reg <= a_code_next;
            b_code_reg <= b_code_next;
            m_code_reg <= m_code_next;
            e_code_reg <= e_code_next;
        end
    end

    always_comb
    begin
        cmd.ok     = sum_ok;
        cmd.ready  = codes_ready(a_code_next, b_code_next, m_code_next, e_code_next);
        cmd.neg    = raw[15];
        cmd.mag    = raw[15] ? (~raw + 16'd1) : raw;
        cmd.unit   = sum_ok ? unit : 2'd0;
        cmd.err    = sum_ok ? error_byte : 8'd0;
        cmd.a_code = a_code_next;
        cmd.b_code = b_code_next;
        cmd.m_code = m_code_next;
        cmd.e_code = e_code_next;
    end

endmodule

>>> rtl/gfpd_fifo.sv
module gfpd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  gfpd_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output gfpd_pkg::cmd_t rd_data,
    output logic           empty
);
    import gfpd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> rtl/gfpd_back.sv
module gfpd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  gfpd_pkg::cmd_t     cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic               res_valid,
    input  logic               res_pop,
    output logic               res_ok,
    output logic signed [63:0] res_pressure,
    output logic [1:0]         res_unit,
    output logic [7:0]         res_err,
    output logic               res_ready
);
    import gfpd_pkg::*;

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg;
    logic [P1_W-1:0]  p1_reg;
    logic [D1_W-1:0]  d1_reg;
    logic [P2_W-1:0]  p2_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             presat_reg;
    logic [QUO_W-1:0] mag_reg;
    logic             sat_reg;
    logic             out_valid_reg, out_valid_next;
    logic             res_load;
    logic             slot_free;
    logic             compute;

    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;
    logic             ge;
    logic [QUO_W:0]   rnd_sum;
    logic [RES_W-1:0] final_p;
    logic             big;

    assign compute   = cmd.ok && cmd.ready;
    assign slot_free = !out_valid_reg || res_pop;
    assign res_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (!cmd_empty)
                    state_next = compute ? ST_MUL_A : ST_DONE;
            ST_MUL_A: state_next = ST_MUL_B;
            ST_MUL_B: state_next = ST_MUL_C;
            ST_MUL_C: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:
                if (cnt_reg == DIV_LAST)
                    state_next = ST_ROUND;
            ST_ROUND: state_next = ST_DONE;
            ST_DONE:
                if (slot_free)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd_pop  = !cmd_empty;
            ST_DONE: res_load = slot_free;
            default:
            begin
                cmd_pop  = 1'b0;
                res_load = 1'b0;
            end
        endcase
    end

    // one quotient bit per step
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign ge    = !diff[DEN_W+1];

    assign rnd_sum = {1'b0, quo_reg} + {{QUO_W{1'b0}}, 1'b1};
    assign big     = (mag_reg[QUO_W-1:RES_W-1] != '0);

    always_comb
    begin
        if (cmd_reg.neg)
            final_p = (sat_reg || big) ? RES_MIN : (~mag_reg[RES_W-1:0] + 64'd1);
        else
            final_p = (sat_reg || big) ? RES_MAX : mag_reg[RES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (res_pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (!cmd_empty)
                    cmd_reg <= cmd;
            ST_MUL_A:
            begin
                p1_reg <= P1_W'(a_num_of(cmd_reg.a_code)) * P1_W'(m_tenths_of(cmd_reg.m_code));
                d1_reg <= D1_W'(a_den_of(cmd_reg.a_code)) * D1_W'(b_val_of(cmd_reg.b_code));
            end
            ST_MUL_B:
            begin
                p2_reg  <= P2_W'(p1_reg) * P2_W'(e_num_of(cmd_reg.e_code));
                den_reg <= DEN_W'(d1_reg) * DEN_W'(e_den10_of(cmd_reg.e_code));
            end
            ST_MUL_C:
                num_reg <= NUM_W'(cmd_reg.mag) * NUM_W'(p2_reg);
            ST_LOAD:
            begin
                rem_reg    <= DEN_W'(num_reg[NUM_W-1:FSH_W]);
                quo_reg    <= {num_reg[FSH_W-1:0], {FSH_W{1'b0}}};
                presat_reg <= (DEN_W'(num_reg[NUM_W-1:FSH_W]) >= den_reg);
                cnt_reg    <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_ROUND:
            begin
                mag_reg <= rnd_sum[QUO_W:1];
                sat_reg <= presat_reg || (quo_reg[QUO_W-1:FSH_W] > INT_LIMIT);
            end
            ST_DONE:
                if (res_load)
                begin
                    res_ok       <= cmd_reg.ok;
                    res_unit     <= cmd_reg.unit;
                    res_err      <= cmd_reg.err;
                    res_ready    <= cmd_reg.ready;
                    res_pressure <= (cmd_reg.ok && cmd_reg.ready) ? signed'(final_p) : '0;
                end
            default:
                cnt_reg <= cnt_reg;
        endcase
    end

endmodule
